// ----- hw/rtl/vfc_pkg.sv -----
// Shared types and codes for the voxel face culling mesher.
// No dependencies; used by vfc_front, vfc_back and the top level.
package vfc_pkg;

  // Input actions
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_START = 2'd2,
    ACT_SCAN  = 2'd3
  } action_e;

  // Result kinds
  localparam logic [2:0] KIND_WACK  = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_FACE  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_START = 3'd4;

  // Face directions
  localparam logic [2:0] DIR_PY = 3'd0;
  localparam logic [2:0] DIR_NY = 3'd1;
  localparam logic [2:0] DIR_PZ = 3'd2;
  localparam logic [2:0] DIR_NZ = 3'd3;
  localparam logic [2:0] DIR_PX = 3'd4;
  localparam logic [2:0] DIR_NX = 3'd5;

  localparam int unsigned VERT_W    = 17;
  localparam logic [VERT_W-1:0] VERT_STEP = 17'd4;

  // Classified command passed from the front to the back
  typedef struct packed {
    action_e     action;
    logic        in_range;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [15:0] value;
  } cmd_t;

endpackage

// ----- hw/rtl/vfc_front.sv -----
// Front end: accepts input items, range-checks coordinates, masks the block
// value and queues the classified commands. Depends on vfc_pkg.
module vfc_front #(
  parameter int GRID_SIDE  = 16,
  parameter int BLOCK_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [7:0]  cell_x_i,
  input  logic signed [7:0]  cell_y_i,
  input  logic signed [7:0]  cell_z_i,
  input  logic [15:0]        block_value_i,
  input  logic               busy_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output vfc_pkg::cmd_t      cmd_o
);

  localparam logic [15:0] VAL_MASK =
    (BLOCK_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << BLOCK_BITS) - 32'd1);
  localparam logic [6:0] SIDE = 7'(GRID_SIDE);

  vfc_pkg::cmd_t queue_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  vfc_pkg::cmd_t cmd_new;
  logic          push, pop;

  // Classify the incoming item
  always_comb begin
    cmd_new.action   = vfc_pkg::action_e'(action_i);
    cmd_new.in_range = !cell_x_i[7] && (cell_x_i[6:0] < SIDE) &&
                       !cell_y_i[7] && (cell_y_i[6:0] < SIDE) &&
                       !cell_z_i[7] && (cell_z_i[6:0] < SIDE);
    cmd_new.x        = cell_x_i;
    cmd_new.y        = cell_y_i;
    cmd_new.z        = cell_z_i;
    cmd_new.value    = block_value_i & VAL_MASK;
  end

  // Hold off new items while full or while the grid is being initialized
  assign in_ready_o  = (cnt_q != 2'd2) && !busy_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2))
    else $error("queue count changed while full without a pop");

endmodule

// ----- hw/rtl/vfc_back.sv -----
// Back end: holds the voxel grid memory and the mesh pass state, and runs
// each command as a short sequence. Depends on vfc_pkg.
module vfc_back #(
  parameter int GRID_SIDE  = 16,
  parameter int BLOCK_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  vfc_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    kind_o,
  output logic [15:0]   read_value_o,
  output logic [3:0]    face_x_o,
  output logic [3:0]    face_y_o,
  output logic [3:0]    face_z_o,
  output logic [2:0]    face_dir_o,
  output logic [16:0]   vertex_base_o,
  output logic          pass_started_o,
  output logic          pass_done_o,
  output logic          last_o
);

  localparam int AW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CW    = 3 * AW;
  localparam int SW    = (BLOCK_BITS < 16) ? BLOCK_BITS : 16;
  localparam int CELLS = 2 ** CW;
  localparam logic [AW-1:0] SIDE_MAX = AW'(GRID_SIDE - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CTR   = 3'd3;
  localparam logic [2:0] S_NBR   = 3'd4;
  localparam logic [2:0] S_NCHK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int VERT_W_L = vfc_pkg::VERT_W;

  // Grid memory
  logic [SW-1:0] grid_mem [CELLS];
  logic [SW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata;

  // Control state
  logic [2:0]        state_q, state_d;
  logic [2:0]        dir_q, dir_d;
  logic [AW-1:0]     cur_x_q, cur_x_d, cur_y_q, cur_y_d, cur_z_q, cur_z_d;
  logic              pass_q, pass_d, dirty_q, dirty_d;
  logic [VERT_W_L-1:0] vcnt_q, vcnt_d;
  logic [CW-1:0]     clr_q, clr_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [2:0]    kind_q, kind_d;
  logic [15:0]   rval_q, rval_d;
  logic [3:0]    fx_q, fx_d, fy_q, fy_d, fz_q, fz_d;
  logic [2:0]    fdir_q, fdir_d;
  logic [16:0]   vb_q, vb_d;
  logic          ps_q, ps_d, pd_q, pd_d, last_q, last_d;

  // Result being formed this cycle
  logic          emit;
  logic [2:0]    e_kind;
  logic [15:0]   e_rval;
  logic          e_coords, e_ps, e_pd, e_last, e_face;

  logic          out_free, pop, cell_last, nb_in;
  logic [AW-1:0] nb_x, nb_y, nb_z;
  logic [7:0]    cx8, cy8, cz8;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign busy_o      = (state_q == S_CLEAR);
  assign cell_last   = (cur_x_q == SIDE_MAX) && (cur_y_q == SIDE_MAX) &&
                       (cur_z_q == SIDE_MAX);
  assign cx8 = 8'(cur_x_q);
  assign cy8 = 8'(cur_y_q);
  assign cz8 = 8'(cur_z_q);

  // Neighbor of the current cell in the current direction
  always_comb begin
    nb_x  = cur_x_q;
    nb_y  = cur_y_q;
    nb_z  = cur_z_q;
    nb_in = 1'b0;
    case (dir_q)
      vfc_pkg::DIR_PY: begin
        nb_in = (cur_y_q != SIDE_MAX);
        nb_y  = cur_y_q + AW'(1);
      end
      vfc_pkg::DIR_NY: begin
        nb_in = (cur_y_q != '0);
        nb_y  = cur_y_q - AW'(1);
      end
      vfc_pkg::DIR_PZ: begin
        nb_in = (cur_z_q != SIDE_MAX);
        nb_z  = cur_z_q + AW'(1);
      end
      vfc_pkg::DIR_NZ: begin
        nb_in = (cur_z_q != '0);
        nb_z  = cur_z_q - AW'(1);
      end
      vfc_pkg::DIR_PX: begin
        nb_in = (cur_x_q != SIDE_MAX);
        nb_x  = cur_x_q + AW'(1);
      end
      vfc_pkg::DIR_NX: begin
        nb_in = (cur_x_q != '0);
        nb_x  = cur_x_q - AW'(1);
      end
      default: nb_in = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    cur_z_d   = cur_z_q;
    pass_d    = pass_q;
    dirty_d   = dirty_q;
    vcnt_d    = vcnt_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {cmd_i.x[AW-1:0], cmd_i.y[AW-1:0], cmd_i.z[AW-1:0]};
    mem_raddr = {cmd_i.x[AW-1:0], cmd_i.y[AW-1:0], cmd_i.z[AW-1:0]};
    mem_wdata = cmd_i.value[SW-1:0];
    emit      = 1'b0;
    e_kind    = vfc_pkg::KIND_WACK;
    e_rval    = '0;
    e_coords  = 1'b0;
    e_face    = 1'b0;
    e_ps      = 1'b0;
    e_pd      = 1'b0;
    e_last    = 1'b1;

    case (state_q)
      // Fill every cell with 1 after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = SW'(1);
        clr_d     = clr_q + CW'(1);
        if (clr_q == {CW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          case (cmd_i.action)
            vfc_pkg::ACT_WRITE: begin
              if (cmd_i.in_range) begin
                mem_we  = 1'b1;
                dirty_d = 1'b1;
              end
              emit   = 1'b1;
              e_kind = vfc_pkg::KIND_WACK;
            end
            vfc_pkg::ACT_READ: begin
              if (cmd_i.in_range) begin
                mem_re  = 1'b1;
                state_d = S_READ;
              end else begin
                emit   = 1'b1;
                e_kind = vfc_pkg::KIND_READ;
              end
            end
            vfc_pkg::ACT_START: begin
              if (dirty_q) begin
                dirty_d = 1'b0;
                pass_d  = 1'b1;
                vcnt_d  = '0;
                cur_x_d = '0;
                cur_y_d = '0;
                cur_z_d = '0;
              end
              emit   = 1'b1;
              e_kind = vfc_pkg::KIND_START;
              e_ps   = dirty_q;
            end
            vfc_pkg::ACT_SCAN: begin
              if (pass_q) begin
                mem_re    = 1'b1;
                mem_raddr = {cur_x_q, cur_y_q, cur_z_q};
                state_d   = S_CTR;
              end else begin
                emit   = 1'b1;
                e_kind = vfc_pkg::KIND_DONE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // Deliver read data once the output register is free
      S_READ: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = vfc_pkg::KIND_READ;
          e_rval  = 16'(rdata_q);
          state_d = S_IDLE;
        end
      end
      // Skip the neighbors of an empty cell
      S_CTR: begin
        if (rdata_q == '0) begin
          state_d = S_DONE;
        end else begin
          dir_d   = vfc_pkg::DIR_PY;
          state_d = S_NBR;
        end
      end
      // Outside neighbor: face at once; inside: fetch it
      S_NBR: begin
        if (nb_in) begin
          mem_re    = 1'b1;
          mem_raddr = {nb_x, nb_y, nb_z};
          state_d   = S_NCHK;
        end else if (out_free) begin
          emit = 1'b1;
          e_face = 1'b1;
        end
      end
      S_NCHK: begin
        if (rdata_q != '0) begin
          state_d = S_NBR;
          if (dir_q == vfc_pkg::DIR_NX) begin
            state_d = S_DONE;
          end else begin
            dir_d = dir_q + 3'd1;
          end
        end else if (out_free) begin
          emit   = 1'b1;
          e_face = 1'b1;
        end
      end
      // Close the cell and advance the cursor: z fastest, then y, then x
      S_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          e_kind   = vfc_pkg::KIND_DONE;
          e_coords = 1'b1;
          e_pd     = cell_last;
          state_d  = S_IDLE;
          if (cell_last) begin
            pass_d  = 1'b0;
            cur_x_d = '0;
            cur_y_d = '0;
            cur_z_d = '0;
          end else if (cur_z_q != SIDE_MAX) begin
            cur_z_d = cur_z_q + AW'(1);
          end else begin
            cur_z_d = '0;
            if (cur_y_q != SIDE_MAX) begin
              cur_y_d = cur_y_q + AW'(1);
            end else begin
              cur_y_d = '0;
              cur_x_d = cur_x_q + AW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Face result: count vertices and step to the next direction, or to S_DONE after the last
    if (e_face) begin
      e_kind   = vfc_pkg::KIND_FACE;
      e_coords = 1'b1;
      e_last   = 1'b0;
      vcnt_d   = vcnt_q + vfc_pkg::VERT_STEP;
      state_d  = S_NBR;
      if (dir_q == vfc_pkg::DIR_NX) begin
        state_d = S_DONE;
      end else begin
        dir_d = dir_q + 3'd1;
      end
    end
  end

  // Load the output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    rval_d      = rval_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    fz_d        = fz_q;
    fdir_d      = fdir_q;
    vb_d        = vb_q;
    ps_d        = ps_q;
    pd_d        = pd_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d      = e_kind;
      rval_d      = e_rval;
      fx_d        = e_coords ? cx8[3:0] : 4'd0;
      fy_d        = e_coords ? cy8[3:0] : 4'd0;
      fz_d        = e_coords ? cz8[3:0] : 4'd0;
      fdir_d      = e_face ? dir_q : 3'd0;
      vb_d        = e_face ? vcnt_q : 17'd0;
      ps_d        = e_ps;
      pd_d        = e_pd;
      last_d      = e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      dir_q       <= vfc_pkg::DIR_PY;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      pass_q      <= 1'b0;
      dirty_q     <= 1'b1;
      vcnt_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cur_z_q     <= cur_z_d;
      pass_q      <= pass_d;
      dirty_q     <= dirty_d;
      vcnt_q      <= vcnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    rval_q <= rval_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    fz_q   <= fz_d;
    fdir_q <= fdir_d;
    vb_q   <= vb_d;
    ps_q   <= ps_d;
    pd_q   <= pd_d;
    last_q <= last_d;
  end

  // Single-port grid with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= grid_mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign read_value_o   = rval_q;
  assign face_x_o       = fx_q;
  assign face_y_o       = fy_q;
  assign face_z_o       = fz_q;
  assign face_dir_o     = fdir_q;
  assign vertex_base_o  = vb_q;
  assign pass_started_o = ps_q;
  assign pass_done_o    = pd_q;
  assign last_o         = last_q;

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re)) else $error("grid written and read in one cycle");

  a_face_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == vfc_pkg::KIND_FACE) |-> pass_q)
    else $error("face result outside a mesh pass");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q == (kind_q != vfc_pkg::KIND_FACE)))
    else $error("last flag does not match result kind");

  a_vcnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcnt_q != $past(vcnt_q)) |->
      (vcnt_q == 17'($past(vcnt_q) + vfc_pkg::VERT_STEP) || vcnt_q == '0))
    else $error("vertex counter moved by other than one face");

endmodule

// ----- hw/rtl/voxel_face_culling_mesher.sv -----
// Voxel face culling mesher: write, read, start and scan items; a scan item
// yields up to six face results and a cell-done result. A filled cell's in-grid
// neighbors are read one at a time through the single grid memory port; the
// back end runs one item at a time behind a two-entry queue. Reset sweeps every
// grid cell to the value 1 with ready low.
module voxel_face_culling_mesher #(
  parameter int GRID_SIDE  = 16,
  parameter int BLOCK_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic signed [7:0] cell_x_i,
  input  logic signed [7:0] cell_y_i,
  input  logic signed [7:0] cell_z_i,
  input  logic [15:0]       block_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [15:0]       read_value_o,
  output logic [3:0]        face_x_o,
  output logic [3:0]        face_y_o,
  output logic [3:0]        face_z_o,
  output logic [2:0]        face_dir_o,
  output logic [16:0]       vertex_base_o,
  output logic              pass_started_o,
  output logic              pass_done_o,
  output logic              last_o
);

  vfc_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready, busy;

  // Classify and queue items
  vfc_front #(
    .GRID_SIDE (GRID_SIDE),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .block_value_i(block_value_i),
    .busy_i       (busy),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  // Execute commands against the grid
  vfc_back #(
    .GRID_SIDE (GRID_SIDE),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .read_value_o  (read_value_o),
    .face_x_o      (face_x_o),
    .face_y_o      (face_y_o),
    .face_z_o      (face_z_o),
    .face_dir_o    (face_dir_o),
    .vertex_base_o (vertex_base_o),
    .pass_started_o(pass_started_o),
    .pass_done_o   (pass_done_o),
    .last_o        (last_o)
  );

endmodule

// ----- dv/testbench.sv -----
// Testbench for voxel_face_culling_mesher: directed and random items are checked
// against a local mirror of the voxel grid and the mesh pass state.
// Depends on vfc_pkg and the mesher RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE            = 16;
  localparam int CELLS           = SIDE * SIDE * SIDE;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_REPORTS     = 10;

  localparam logic [2:0] FACE_DIRS [6] = '{vfc_pkg::DIR_PY, vfc_pkg::DIR_NY,
                                           vfc_pkg::DIR_PZ, vfc_pkg::DIR_NZ,
                                           vfc_pkg::DIR_PX, vfc_pkg::DIR_NX};
  localparam logic signed [7:0] EDGE_COORDS [6] = '{8'sh80, -8'sd1, 8'sd0, 8'sd15,
                                                    8'sd16, 8'sd127};

  typedef struct {
    vfc_pkg::action_e  act;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] z;
    logic [15:0]       value;
  } voxel_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] read_value;
    logic [3:0]  fx;
    logic [3:0]  fy;
    logic [3:0]  fz;
    logic [2:0]  dir;
    logic [16:0] vbase;
    logic        started;
    logic        done;
    logic        last;
  } mesh_rec_t;

  // Block ports
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i      = '0;
  logic signed [7:0] cell_x_i      = '0;
  logic signed [7:0] cell_y_i      = '0;
  logic signed [7:0] cell_z_i      = '0;
  logic [15:0]       block_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [2:0]        kind_o;
  logic [15:0]       read_value_o;
  logic [3:0]        face_x_o;
  logic [3:0]        face_y_o;
  logic [3:0]        face_z_o;
  logic [2:0]        face_dir_o;
  logic [16:0]       vertex_base_o;
  logic              pass_started_o;
  logic              pass_done_o;
  logic              last_o;

  // Mirror of the block state
  logic [15:0] grid_mirror [CELLS];
  logic        mirror_dirty;
  logic        mirror_active;
  logic [11:0] mirror_cursor;
  logic [16:0] mirror_verts;

  voxel_item_t item_queue [$];
  voxel_item_t offered;
  mesh_rec_t   expected_recs [$];
  bit          in_taken;
  int          fail_count    = 0;
  int          idle_cycles   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;
  int          hold_cnt      = 0;

  voxel_face_culling_mesher DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_z_i       (cell_z_i),
    .block_value_i  (block_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .read_value_o   (read_value_o),
    .face_x_o       (face_x_o),
    .face_y_o       (face_y_o),
    .face_z_o       (face_z_o),
    .face_dir_o     (face_dir_o),
    .vertex_base_o  (vertex_base_o),
    .pass_started_o (pass_started_o),
    .pass_done_o    (pass_done_o),
    .last_o         (last_o)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && x < SIDE && y >= 0 && y < SIDE && z >= 0 && z < SIDE;
  endfunction

  function automatic int cell_addr(int x, int y, int z);
    return (x * SIDE + y) * SIDE + z;
  endfunction

  function automatic logic [15:0] cell_at(int x, int y, int z);
    if (!in_grid(x, y, z)) return '0;
    return grid_mirror[cell_addr(x, y, z)];
  endfunction

  // Work out the records one item produces and advance the mirror
  function automatic void predict_mesh(voxel_item_t it);
    mesh_rec_t rec;
    mesh_rec_t face;
    int        cx, cy, cz, nx, ny, nz;
    rec      = '0;
    rec.last = 1'b1;
    case (it.act)
      vfc_pkg::ACT_WRITE: begin
        if (in_grid(it.x, it.y, it.z)) begin
          grid_mirror[cell_addr(it.x, it.y, it.z)] = it.value;
          mirror_dirty = 1'b1;
        end
        rec.kind = vfc_pkg::KIND_WACK;
      end
      vfc_pkg::ACT_READ: begin
        rec.kind       = vfc_pkg::KIND_READ;
        rec.read_value = cell_at(it.x, it.y, it.z);
      end
      vfc_pkg::ACT_START: begin
        rec.kind = vfc_pkg::KIND_START;
        if (mirror_dirty) begin
          mirror_dirty  = 1'b0;
          mirror_cursor = '0;
          mirror_verts  = '0;
          mirror_active = 1'b1;
          rec.started   = 1'b1;
        end
      end
      default: begin
        rec.kind = vfc_pkg::KIND_DONE;
        if (mirror_active) begin
          cx = mirror_cursor[11:8];
          cy = mirror_cursor[7:4];
          cz = mirror_cursor[3:0];
          // Emit a face toward each empty or outside neighbor
          if (grid_mirror[mirror_cursor] != '0) begin
            foreach (FACE_DIRS[i]) begin
              nx = cx;
              ny = cy;
              nz = cz;
              case (FACE_DIRS[i])
                vfc_pkg::DIR_PY: ny++;
                vfc_pkg::DIR_NY: ny--;
                vfc_pkg::DIR_PZ: nz++;
                vfc_pkg::DIR_NZ: nz--;
                vfc_pkg::DIR_PX: nx++;
                default:         nx--;
              endcase
              if (cell_at(nx, ny, nz) == '0) begin
                face       = '0;
                face.kind  = vfc_pkg::KIND_FACE;
                face.fx    = 4'(cx);
                face.fy    = 4'(cy);
                face.fz    = 4'(cz);
                face.dir   = FACE_DIRS[i];
                face.vbase = mirror_verts;
                expected_recs = {expected_recs, face};
                mirror_verts = mirror_verts + vfc_pkg::VERT_STEP;
              end
            end
          end
          rec.fx   = 4'(cx);
          rec.fy   = 4'(cy);
          rec.fz   = 4'(cz);
          rec.done = (mirror_cursor == 12'(CELLS - 1));
          if (rec.done) begin
            mirror_active = 1'b0;
            mirror_cursor = '0;
          end else begin
            mirror_cursor = mirror_cursor + 12'd1;
          end
        end
      end
    endcase
    expected_recs = {expected_recs, rec};
  endfunction

  function automatic string rec_text(mesh_rec_t r);
    return $sformatf("kind=%0d rd=%h xyz=%0d/%0d/%0d dir=%0d vb=%0d st=%b dn=%b last=%b",
                     r.kind, r.read_value, r.fx, r.fy, r.fz, r.dir, r.vbase,
                     r.started, r.done, r.last);
  endfunction

  function automatic void note_failure(string what, string want_txt, mesh_rec_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected %s, got %s", what, want_txt, rec_text(got));
  endfunction

  function automatic void queue_item(vfc_pkg::action_e act, int x, int y, int z,
                                     int value);
    voxel_item_t it;
    it.act   = act;
    it.x     = 8'(x);
    it.y     = 8'(y);
    it.z     = 8'(z);
    it.value = 16'(value);
    item_queue = {item_queue, it};
  endfunction

  // Mostly scans, starts and writes near the front of the scan order, plus noise
  function automatic voxel_item_t random_item();
    voxel_item_t it;
    int          pick;
    pick     = $urandom_range(99);
    it.act   = vfc_pkg::ACT_SCAN;
    it.x     = 8'($urandom);
    it.y     = 8'($urandom);
    it.z     = 8'($urandom);
    it.value = 16'($urandom);
    if (pick < 35) begin
      it.act = vfc_pkg::ACT_SCAN;
    end else if (pick < 60) begin
      it.act = vfc_pkg::ACT_WRITE;
      it.x   = ($urandom_range(3) == 0) ? 8'sd1 : 8'sd0;
      it.y   = 8'($urandom_range(3));
      it.z   = 8'($urandom_range(SIDE - 1));
      if ($urandom_range(1) == 0) it.value = '0;
    end else if (pick < 70) begin
      it.act = vfc_pkg::ACT_READ;
      it.x   = 8'($urandom_range(SIDE - 1));
      it.y   = 8'($urandom_range(SIDE - 1));
      it.z   = 8'($urandom_range(SIDE - 1));
    end else if (pick < 78) begin
      it.act = vfc_pkg::ACT_START;
    end else if (pick < 88) begin
      it.act = ($urandom_range(1) == 0) ? vfc_pkg::ACT_WRITE : vfc_pkg::ACT_READ;
      it.x   = EDGE_COORDS[$urandom_range(5)];
      it.y   = EDGE_COORDS[$urandom_range(5)];
      it.z   = EDGE_COORDS[$urandom_range(5)];
    end else begin
      it.act = vfc_pkg::action_e'($urandom_range(3));
    end
    return it;
  endfunction

  function automatic void queue_random(int count);
    repeat (count) item_queue = {item_queue, random_item()};
  endfunction

  // Hold until every item is taken and every record has come back
  task automatic wait_drained();
    while (item_queue.size() != 0 || in_valid_i || expected_recs.size() != 0)
      @(posedge clk_i);
  endtask

  // Offer the next pending item, or idle
  always @(negedge clk_i) begin : send_drive
    if (!in_valid_i || in_taken) begin
      if (rst_ni && item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = item_queue.pop_front();
        action_i      <= offered.act;
        cell_x_i      <= offered.x;
        cell_y_i      <= offered.y;
        cell_z_i      <= offered.z;
        block_value_i <= offered.value;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or hold off for a requested stretch
  always @(negedge clk_i) begin : recv_drive
    if (hold_cnt < hold_req) begin
      hold_cnt    <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predict on item acceptance, compare results, and watch for a hang
  always @(posedge clk_i) begin : check_results
    mesh_rec_t got;
    mesh_rec_t want;
    bit        out_taken;
    in_taken  = in_valid_i && in_ready_o;
    out_taken = out_valid_o && out_ready_i;
    if (in_taken) predict_mesh(offered);
    if (out_taken) begin
      got = '{kind_o, read_value_o, face_x_o, face_y_o, face_z_o, face_dir_o,
              vertex_base_o, pass_started_o, pass_done_o, last_o};
      if (expected_recs.size() == 0) begin
        note_failure("unexpected record", "none", got);
      end else begin
        want = expected_recs.pop_front();
        if (got.kind !== want.kind || got.read_value !== want.read_value ||
            got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
            got.dir !== want.dir || got.vbase !== want.vbase ||
            got.started !== want.started || got.done !== want.done ||
            got.last !== want.last)
          note_failure("record mismatch", rec_text(want), got);
      end
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("voxel_face_culling_mesher: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    foreach (grid_mirror[i]) grid_mirror[i] = 16'd1;
    mirror_dirty  = 1'b1;
    mirror_active = 1'b0;
    mirror_cursor = '0;
    mirror_verts  = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset contents, out-of-range access, idle scan, clean and dirty
    // start, writes seen by the running pass, restart
    queue_item(vfc_pkg::ACT_READ, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_READ, 15, 15, 15, 0);
    queue_item(vfc_pkg::ACT_READ, -1, 0, 0, 0);
    queue_item(vfc_pkg::ACT_READ, 16, 127, -128, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_START, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_START, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_WRITE, 0, 0, 1, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_WRITE, 0, 0, 3, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_WRITE, -128, -1, 16, 16'hFFFF);
    queue_item(vfc_pkg::ACT_WRITE, 127, 127, 127, 16'hFFFF);
    queue_item(vfc_pkg::ACT_READ, 127, 127, 127, 0);
    queue_item(vfc_pkg::ACT_WRITE, 15, 15, 15, 16'hFFFF);
    queue_item(vfc_pkg::ACT_READ, 15, 15, 15, 0);
    queue_item(vfc_pkg::ACT_START, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_WRITE, 1, 0, 0, 0);
    queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_READ, 0, 0, 3, 0);
    queue_item(vfc_pkg::ACT_WRITE, 0, 0, 0, 16'h8000);
    queue_item(vfc_pkg::ACT_READ, 0, 0, 0, 0);
    wait_drained();

    // Random, no idling, with a long result hold-off so the input backs up
    queue_random(100);
    hold_req = hold_cnt + HOLD_OFF_CYCLES;
    wait_drained();

    send_idle_pct = 65;
    stall_pct     = 0;
    queue_random(95);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 65;
    queue_random(95);
    wait_drained();

    send_idle_pct = 25;
    stall_pct     = 25;
    queue_random(95);
    wait_drained();

    // A short pass over cells with holes near the scan start, then a clean start
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (20)
      queue_item(vfc_pkg::ACT_WRITE, 0, $urandom_range(1), $urandom_range(SIDE - 1),
                 ($urandom_range(1) == 0) ? 0 : $urandom);
    queue_item(vfc_pkg::ACT_START, 0, 0, 0, 0);
    repeat (20) queue_item(vfc_pkg::ACT_SCAN, 0, 0, 0, 0);
    queue_item(vfc_pkg::ACT_START, 0, 0, 0, 0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("voxel_face_culling_mesher: match");
    end else begin
      $display("voxel_face_culling_mesher: mismatch");
    end
    $finish;
  end

endmodule
